/* rtl/text_console_cursor_engine_assert.svh */
// Assertion macros shared by the console engine RTL.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define TCCE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed: condition violated");

// Consequence holds in the same cycle as the antecedent.
`define TCCE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

// Consequence holds in the cycle after the antecedent.
`define TCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");

`endif

/* rtl/tcce_pkg.sv */
`timescale 1ns / 1ps

package tcce_pkg;

    // Screen geometry
    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int TAB_STOP       = 8;

    localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int LAST_ROW_BASE = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int COL_W  = $clog2(SCREEN_COLUMNS);
    localparam int ROW_W  = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
    localparam int ROWN_W = ROW_W + 1;
    localparam int CT_W   = $clog2(SCREEN_COLUMNS + TAB_STOP + 1);
    localparam int COL_DEPTH = 2 ** COL_W;

    // Fixed field widths
    localparam int FUNC_W = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int IDX_W  = 11;
    localparam int CELL_W = 16;

    // Character codes
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CODE_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CODE_LF        = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_CR        = 8'h0D;
    localparam logic [CHAR_W-1:0] CODE_BLANK     = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTRIBUTE = 8'h03;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [CT_W-1:0]   t_ctab;
    typedef logic [CELL_W-1:0] t_cell;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    // Outcome of one put-character request
    typedef struct packed {
        logic  wr_en;
        t_addr wr_addr;
        t_col  col;
        t_row  row;
        logic  scroll;
    } t_put_result;

    typedef t_ctab t_tab_lut [COL_DEPTH];

    // Next tab stop for each column, built at elaboration
    function automatic t_tab_lut build_tab_lut();
        t_tab_lut lut;
        for (int i = 0; i < COL_DEPTH; i++) begin
            lut[i] = CT_W'((i / TAB_STOP + 1) * TAB_STOP);
        end
        return lut;
    endfunction

    localparam t_tab_lut TAB_LUT = build_tab_lut();

    function automatic t_cell make_cell(logic [ATTR_W-1:0] attr, logic [CHAR_W-1:0] ch);
        return {attr, ch};
    endfunction

    function automatic t_addr cell_index(t_row row, t_col col);
        return t_addr'(row) * t_addr'(SCREEN_COLUMNS) + t_addr'(col);
    endfunction

endpackage

/* rtl/tcce_req_if.sv */
`timescale 1ns / 1ps

interface tcce_req_if import tcce_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [CHAR_W-1:0]   char_code;
    logic [IDX_W-1:0]    cell_address;

    modport source (output valid, output func, output char_code, output cell_address,
                    input ready);
    modport sink   (input valid, input func, input char_code, input cell_address,
                    output ready);
endinterface

/* rtl/tcce_rsp_if.sv */
`timescale 1ns / 1ps

interface tcce_rsp_if import tcce_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    cursor_position;
    logic [CELL_W-1:0]   cell_value;
    logic                scrolled;

    modport source (output valid, output cursor_position, output cell_value,
                    output scrolled, input ready);
    modport sink   (input valid, input cursor_position, input cell_value,
                    input scrolled, output ready);
endinterface

/* rtl/tcce_cfg_if.sv */
`timescale 1ns / 1ps

interface tcce_cfg_if import tcce_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ATTR_W-1:0]   display_attribute;

    modport source (output valid, output display_attribute, input ready);
    modport sink   (input valid, input display_attribute, output ready);
endinterface

/* rtl/text_console_cursor_engine.sv */
`timescale 1ns / 1ps
// Text console engine: screen cell memory plus cursor.
// i_req carries one request (func, char_code, cell_address); o_rsp returns exactly one
// response per request (cursor_position, cell_value, scrolled); i_cfg writes the
// display attribute and is always ready.
// Requests are taken one at a time: i_req.ready is high only while the sequencer idles.
// Put character, read cell and the unused func pass from accept to ST_DONE, which loads
// the response register once it is free and then idles. A clear sweeps the screen
// memory one cell per cycle. A put that scrolls copies every row up through the one
// read and one write port of the screen memory and blanks the last row. The memory
// ports and the shared address counter pace the clear and the scroll sweeps.
// After reset the same sweep blanks all cells with attribute 0x03, during which no
// request is accepted; attribute writes are taken.
// The response sits in an output register; when the receiver stalls, the finished
// response holds and the next request is accepted meanwhile, but its response waits
// until the register is emptied.

`include "text_console_cursor_engine_assert.svh"

module text_console_cursor_engine import tcce_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    tcce_req_if.sink    i_req,
    tcce_rsp_if.source  o_rsp,
    tcce_cfg_if.sink    i_cfg
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCROLL_START,
        ST_SCROLL,
        ST_FILL,
        ST_DONE
    } t_state;

    t_state            r_state;
    logic              r_init;
    t_addr             r_cnt;
    t_col              r_col;
    t_row              r_row;
    logic [ATTR_W-1:0] r_attr;
    t_func             r_func;
    logic              r_rd_ok;
    logic              r_scrolled;

    logic              r_o_valid;
    logic [IDX_W-1:0]  r_o_cursor;
    t_cell             r_o_data;
    logic              r_o_scrolled;

    t_put_result       put;
    logic              accept;
    t_func             req_func;
    logic              req_in_range;
    logic [ADDR_W:0]   src_next;
    t_cell             blank;

    logic              mem_we;
    t_addr             mem_waddr;
    t_cell             mem_wdata;
    logic              mem_re;
    t_addr             mem_raddr;
    t_cell             mem_rdata;

    logic              cursor_ok;
    logic              scroll_home_ok;

    tcce_cursor_unit u_cursor (
        .i_char_code (i_req.char_code),
        .i_col       (r_col),
        .i_row       (r_row),
        .o_put       (put)
    );

    tcce_screen_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign req_func    = t_func'(i_req.func);
    assign req_in_range = (int'(i_req.cell_address) < CELL_COUNT);
    assign src_next    = (ADDR_W + 1)'(r_cnt) + (ADDR_W + 1)'(SCREEN_COLUMNS + 1);
    assign blank       = make_cell(r_init ? RESET_ATTRIBUTE : r_attr, CODE_BLANK);

    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid           = r_o_valid;
    assign o_rsp.cursor_position = r_o_cursor;
    assign o_rsp.cell_value      = r_o_data;
    assign o_rsp.scrolled        = r_o_scrolled;

    assign cursor_ok      = (int'(r_row) < SCREEN_ROWS) && (int'(r_col) < SCREEN_COLUMNS);
    assign scroll_home_ok = (r_col == '0) && (int'(r_row) == SCREEN_ROWS - 1);

    // Steer the memory ports from the sequencer
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cnt;
        mem_wdata = blank;
        mem_re    = 1'b0;
        mem_raddr = t_addr'(SCREEN_COLUMNS);
        unique case (r_state)
            ST_IDLE: begin
                mem_we    = accept && (req_func == FUNC_PUT) && put.wr_en;
                mem_waddr = put.wr_addr;
                mem_wdata = make_cell(r_attr, i_req.char_code);
                mem_re    = accept && (req_func == FUNC_READ) && req_in_range;
                mem_raddr = t_addr'(i_req.cell_address);
            end
            ST_SCROLL_START: begin
                mem_re = 1'b1;
            end
            ST_SCROLL: begin
                mem_we    = 1'b1;
                mem_wdata = (int'(r_cnt) < LAST_ROW_BASE) ? mem_rdata : blank;
                mem_re    = (int'(src_next) < CELL_COUNT);
                mem_raddr = t_addr'(src_next);
            end
            ST_FILL: begin
                mem_we = 1'b1;
            end
            ST_DONE: begin
                mem_we = 1'b0;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Sequencer, cursor and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_FILL;
            r_init     <= 1'b1;
            r_cnt      <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_attr     <= RESET_ATTRIBUTE;
            r_o_valid  <= 1'b0;
            r_func     <= FUNC_NONE;
            r_rd_ok    <= 1'b0;
            r_scrolled <= 1'b0;
        end else begin
            // Take attribute writes at any time
            if (i_cfg.valid) begin
                r_attr <= i_cfg.display_attribute;
            end

            // Drop the response once taken
            if (o_rsp.ready && (r_state != ST_DONE)) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_func  <= req_func;
                        r_rd_ok <= req_in_range;
                        unique case (req_func)
                            FUNC_PUT: begin
                                r_col      <= put.col;
                                r_row      <= put.row;
                                r_scrolled <= put.scroll;
                                r_state    <= put.scroll ? ST_SCROLL_START : ST_DONE;
                            end
                            FUNC_CLEAR: begin
                                r_col      <= '0;
                                r_row      <= '0;
                                r_cnt      <= '0;
                                r_scrolled <= 1'b0;
                                r_state    <= ST_FILL;
                            end
                            FUNC_READ, FUNC_NONE: begin
                                r_scrolled <= 1'b0;
                                r_state    <= ST_DONE;
                            end
                            default: begin
                                r_scrolled <= 1'b0;
                                r_state    <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_SCROLL_START: begin
                    r_cnt   <= '0;
                    r_state <= ST_SCROLL;
                end
                ST_SCROLL: begin
                    if (int'(r_cnt) == CELL_COUNT - 1) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_cnt <= r_cnt + t_addr'(1);
                    end
                end
                ST_FILL: begin
                    if (int'(r_cnt) == CELL_COUNT - 1) begin
                        r_init  <= 1'b0;
                        r_state <= r_init ? ST_IDLE : ST_DONE;
                    end else begin
                        r_cnt <= r_cnt + t_addr'(1);
                    end
                end
                ST_DONE: begin
                    // Load the response once the register is free
                    if (!r_o_valid || o_rsp.ready) begin
                        r_o_valid    <= 1'b1;
                        r_o_cursor   <= IDX_W'(cell_index(r_row, r_col));
                        r_o_data     <= ((r_func == FUNC_READ) && r_rd_ok) ? mem_rdata : '0;
                        r_o_scrolled <= r_scrolled;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `TCCE_ASSERT_ALWAYS(a_cursor_range, i_clk, i_rst_n, cursor_ok)
    `TCCE_ASSERT_IMPLY(a_scroll_home, i_clk, i_rst_n, (r_state == ST_DONE) && r_scrolled, scroll_home_ok)
    `TCCE_ASSERT_NEXT(a_scroll_start, i_clk, i_rst_n, r_state == ST_SCROLL_START, (r_state == ST_SCROLL) && (r_cnt == '0))

endmodule

/* rtl/tcce_screen_ram.sv */
`timescale 1ns / 1ps

module tcce_screen_ram import tcce_pkg::*; (
    input  logic  i_clk,
    input  logic  i_we,
    input  t_addr i_waddr,
    input  t_cell i_wdata,
    input  logic  i_re,
    input  t_addr i_raddr,
    output t_cell o_rdata
);

    t_cell r_mem [CELL_COUNT];
    t_cell r_rdata;

    // Write one cell per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tcce_cursor_unit.sv */
`timescale 1ns / 1ps

module tcce_cursor_unit import tcce_pkg::*; (
    input  logic [CHAR_W-1:0] i_char_code,
    input  t_col              i_col,
    input  t_row              i_row,
    output t_put_result       o_put
);

    // Decode the character and advance the cursor
    always_comb begin
        t_ctab             col_n;
        logic [ROWN_W-1:0] row_n;
        logic              wr;
        col_n = CT_W'(i_col);
        row_n = ROWN_W'(i_row);
        wr    = 1'b0;

        priority if (i_char_code == CODE_BACKSPACE) begin
            if (i_col != '0) begin
                col_n = CT_W'(i_col) - CT_W'(1);
            end
        end else if (i_char_code == CODE_TAB) begin
            col_n = TAB_LUT[i_col];
        end else if (i_char_code == CODE_CR) begin
            col_n = '0;
        end else if (i_char_code == CODE_LF) begin
            col_n = '0;
            row_n = row_n + ROWN_W'(1);
        end else if (i_char_code >= CODE_BLANK) begin
            wr    = 1'b1;
            col_n = CT_W'(i_col) + CT_W'(1);
        end else begin
            col_n = CT_W'(i_col);
        end

        // Wrap past the last column
        if (col_n >= CT_W'(SCREEN_COLUMNS)) begin
            col_n = '0;
            row_n = row_n + ROWN_W'(1);
        end

        o_put.wr_en   = wr;
        o_put.wr_addr = cell_index(i_row, i_col);
        o_put.col     = COL_W'(col_n);
        o_put.scroll  = (row_n == ROWN_W'(SCREEN_ROWS));
        o_put.row     = o_put.scroll ? ROW_W'(SCREEN_ROWS - 1) : ROW_W'(row_n);
    end

endmodule

/* test/tb_text_console_cursor_engine.sv */
`timescale 1ns / 1ps

module tb_text_console_cursor_engine;
    import tcce_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 6;
    localparam int PHASE_COUNT     = 5;
    localparam int PHASE_REQUESTS  = 110;
    localparam int LONG_HOLD       = 600;
    localparam int SETTLE_CYCLES   = 50;
    localparam int CYCLE_LIMIT     = 5_000_000;
    localparam int ADDR_SPAN       = 2 ** IDX_W;

    typedef struct packed {
        t_func             func;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_address;
    } t_console_cmd;

    typedef struct packed {
        logic [IDX_W-1:0]  cursor_position;
        logic [CELL_W-1:0] cell_value;
        logic              scrolled;
    } t_console_reply;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tcce_req_if req_if ();
    tcce_rsp_if rsp_if ();
    tcce_cfg_if cfg_if ();

    text_console_cursor_engine uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // Shadow of the screen, the cursor and the attribute register
    logic [CELL_W-1:0] shadow_cells [CELL_COUNT];
    int                shadow_col;
    int                shadow_row;
    logic [ATTR_W-1:0] shadow_attr;

    t_console_cmd   queued_commands [$];
    t_console_reply predicted_replies [$];
    t_console_cmd   offered_cmd;

    int  burst_left;
    int  gap_left;
    int  hold_left;
    int  pattern_age;
    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  sent_count = 0;
    int  reply_count = 0;
    logic [15:0] stall_pattern;
    logic [3:0]  pattern_pos;
    logic        long_hold_armed = 1'b0;
    logic        long_hold_done;

    always #CLK_HALF i_clk = ~i_clk;

    // Apply one accepted request to the shadow state and return the reply it earns
    function automatic t_console_reply console_step(t_console_cmd cmd);
        t_console_reply reply;
        int             idx;
        reply = '0;
        case (cmd.func)
            FUNC_PUT: begin
                if (cmd.char_code == CODE_BACKSPACE) begin
                    if (shadow_col != 0) shadow_col = shadow_col - 1;
                end else if (cmd.char_code == CODE_TAB) begin
                    shadow_col = (shadow_col / TAB_STOP + 1) * TAB_STOP;
                end else if (cmd.char_code == CODE_CR) begin
                    shadow_col = 0;
                end else if (cmd.char_code == CODE_LF) begin
                    shadow_row = shadow_row + 1;
                    shadow_col = 0;
                end else if (cmd.char_code >= CODE_BLANK) begin
                    idx = shadow_row * SCREEN_COLUMNS + shadow_col;
                    if (idx < CELL_COUNT) shadow_cells[idx] = {shadow_attr, cmd.char_code};
                    shadow_col = shadow_col + 1;
                end
                // Wrap past the last column
                if (shadow_col >= SCREEN_COLUMNS) begin
                    shadow_col = 0;
                    shadow_row = shadow_row + 1;
                end
                // Scroll up one row and blank the bottom row
                if (shadow_row >= SCREEN_ROWS) begin
                    for (int k = 0; k < LAST_ROW_BASE; k++)
                        shadow_cells[k] = shadow_cells[k + SCREEN_COLUMNS];
                    for (int k = LAST_ROW_BASE; k < CELL_COUNT; k++)
                        shadow_cells[k] = {shadow_attr, CODE_BLANK};
                    shadow_row = SCREEN_ROWS - 1;
                    reply.scrolled = 1'b1;
                end
            end
            FUNC_READ: begin
                if (cmd.cell_address < CELL_COUNT) reply.cell_value = shadow_cells[cmd.cell_address];
            end
            FUNC_CLEAR: begin
                for (int k = 0; k < CELL_COUNT; k++) shadow_cells[k] = {shadow_attr, CODE_BLANK};
                shadow_col = 0;
                shadow_row = 0;
            end
            default: ;
        endcase
        reply.cursor_position = IDX_W'(shadow_row * SCREEN_COLUMNS + shadow_col);
        return reply;
    endfunction

    function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch on %s: expected %h, got %h", field, want, got);
        end
    endfunction

    function automatic void push_cmd(t_func func, logic [CHAR_W-1:0] code,
                                     logic [IDX_W-1:0] addr);
        t_console_cmd cmd;
        cmd.func         = func;
        cmd.char_code    = code;
        cmd.cell_address = addr;
        queued_commands.push_back(cmd);
        sent_count++;
    endfunction

    // Mostly text with line control, some reads, a few clears and unused funcs
    function automatic t_console_cmd random_cmd();
        t_console_cmd cmd;
        int unsigned  pick;
        int unsigned  kind;
        cmd.func         = FUNC_PUT;
        cmd.char_code    = CHAR_W'($urandom);
        cmd.cell_address = IDX_W'($urandom);
        pick = $urandom_range(0, 999);
        kind = $urandom_range(0, 99);
        if (pick < 800) begin
            if (kind < 55)      cmd.char_code = CHAR_W'($urandom_range(CODE_BLANK, 8'h7E));
            else if (kind < 65) cmd.char_code = CHAR_W'($urandom_range(8'h80, 8'hFF));
            else if (kind < 77) cmd.char_code = CODE_LF;
            else if (kind < 81) cmd.char_code = CODE_CR;
            else if (kind < 88) cmd.char_code = CODE_TAB;
            else if (kind < 93) cmd.char_code = CODE_BACKSPACE;
            else if (kind < 97) cmd.char_code = CHAR_W'($urandom_range(0, CODE_BLANK - 1));
        end else if (pick < 950) begin
            cmd.func = FUNC_READ;
            if (kind < 50)      cmd.cell_address = IDX_W'($urandom_range(0, CELL_COUNT - 1));
            else if (kind < 70)
                cmd.cell_address = IDX_W'($urandom_range(LAST_ROW_BASE, CELL_COUNT - 1));
            else if (kind < 85) cmd.cell_address = IDX_W'($urandom_range(0, SCREEN_COLUMNS - 1));
            else cmd.cell_address = IDX_W'($urandom_range(CELL_COUNT, ADDR_SPAN - 1));
        end else if (pick < 995) begin
            cmd.func = FUNC_NONE;
        end else begin
            cmd.func = FUNC_CLEAR;
        end
        return cmd;
    endfunction

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        cfg_if.valid             <= 1'b1;
        cfg_if.display_attribute <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        shadow_attr = value;
    endtask

    // Wait until every queued request has been answered
    task automatic wait_drained();
        while (reply_count != sent_count)
            @(posedge i_clk);
    endtask

    // Request driver: offer requests in bursts, predict each one as it is accepted
    always @(posedge i_clk) begin : request_driver
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                predicted_replies.push_back(console_step(offered_cmd));
                burst_left = burst_left - 1;
            end
            if (!req_if.valid || req_if.ready) begin
                if (burst_left <= 0 && gap_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
                if (burst_left > 0 && queued_commands.size() > 0) begin
                    offered_cmd = queued_commands.pop_front();
                    req_if.valid        <= 1'b1;
                    req_if.func         <= offered_cmd.func;
                    req_if.char_code    <= offered_cmd.char_code;
                    req_if.cell_address <= offered_cmd.cell_address;
                end else begin
                    req_if.valid <= 1'b0;
                    if (burst_left <= 0 && gap_left > 0) gap_left = gap_left - 1;
                end
            end
        end
    end

    // Reply receiver: stall on a rotating pattern, with one long hold-off when armed
    always @(posedge i_clk) begin : reply_receiver
        if (!i_rst_n) begin
            rsp_if.ready  <= 1'b0;
            hold_left      = 0;
            pattern_age    = 0;
            pattern_pos    = '0;
            stall_pattern  = 16'hFFFF;
            long_hold_done = 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_if.ready <= (hold_left == 0);
        end else if (long_hold_armed && !long_hold_done && rsp_if.valid) begin
            hold_left      = LONG_HOLD;
            long_hold_done = 1'b1;
            rsp_if.ready  <= 1'b0;
        end else begin
            if (pattern_age == 0) begin
                stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
                if (stall_pattern == '0) stall_pattern = 16'h0001;
                pattern_age = 48;
            end
            pattern_age = pattern_age - 1;
            rsp_if.ready <= stall_pattern[pattern_pos];
            pattern_pos  = pattern_pos + 1'b1;
        end
    end

    // Reply monitor: compare each accepted reply with the oldest prediction
    always @(posedge i_clk) begin : reply_monitor
        t_console_reply want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (predicted_replies.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("reply with none pending: cursor %h data %h scrolled %b",
                             rsp_if.cursor_position, rsp_if.cell_value, rsp_if.scrolled);
            end else begin
                want = predicted_replies.pop_front();
                reply_count++;
                check_field("cursor_position", 16'(want.cursor_position),
                            16'(rsp_if.cursor_position));
                check_field("cell_value", want.cell_value, rsp_if.cell_value);
                check_field("scrolled", 16'(want.scrolled), 16'(rsp_if.scrolled));
            end
        end
    end

    // Cycle watchdog
    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        logic [ATTR_W-1:0] phase_attrs [PHASE_COUNT];

        req_if.valid             = 1'b0;
        req_if.func              = FUNC_PUT;
        req_if.char_code         = '0;
        req_if.cell_address      = '0;
        rsp_if.ready             = 1'b0;
        cfg_if.valid             = 1'b0;
        cfg_if.display_attribute = '0;
        i_rst_n                  = 1'b0;

        for (int k = 0; k < CELL_COUNT; k++) shadow_cells[k] = {RESET_ATTRIBUTE, CODE_BLANK};
        shadow_col  = 0;
        shadow_row  = 0;
        shadow_attr = RESET_ATTRIBUTE;

        phase_attrs[0] = 8'h00;
        phase_attrs[1] = ATTR_W'($urandom);
        phase_attrs[2] = 8'hFF;
        phase_attrs[3] = ATTR_W'($urandom);
        phase_attrs[4] = ATTR_W'($urandom);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_attribute(8'hFF);

        // Reset contents, address extremes, every control code and func
        push_cmd(FUNC_READ, '0, '0);
        push_cmd(FUNC_READ, '0, IDX_W'(CELL_COUNT - 1));
        push_cmd(FUNC_READ, '0, '1);
        push_cmd(FUNC_PUT, 8'h41, '0);
        push_cmd(FUNC_PUT, 8'hFF, '0);
        push_cmd(FUNC_PUT, CODE_BLANK, '0);
        push_cmd(FUNC_PUT, CODE_BACKSPACE, '0);
        push_cmd(FUNC_PUT, CODE_CR, '0);
        // backspace at column 0 holds the cursor
        push_cmd(FUNC_PUT, CODE_BACKSPACE, '0);
        push_cmd(FUNC_PUT, CODE_TAB, '0);
        push_cmd(FUNC_PUT, CODE_TAB, '0);
        // control codes without a rule
        push_cmd(FUNC_PUT, 8'h00, '1);
        push_cmd(FUNC_PUT, CHAR_W'(CODE_BLANK - 1), '0);
        push_cmd(FUNC_PUT, CODE_LF, '0);
        push_cmd(FUNC_PUT, 8'h7E, '0);
        push_cmd(FUNC_NONE, 8'hFF, '1);
        push_cmd(FUNC_READ, '0, IDX_W'(0));
        push_cmd(FUNC_READ, '0, IDX_W'(1));
        push_cmd(FUNC_READ, '0, IDX_W'(SCREEN_COLUMNS));
        push_cmd(FUNC_CLEAR, '0, '0);
        push_cmd(FUNC_READ, '0, IDX_W'(0));
        push_cmd(FUNC_READ, '0, IDX_W'(CELL_COUNT - 1));
        wait_drained();

        // Random phases, each under its own attribute; one of them sees the long hold
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_attribute(phase_attrs[p]);
            if (p == 2) long_hold_armed = 1'b1;
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                queued_commands.push_back(random_cmd());
                sent_count++;
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && predicted_replies.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
